@@ rtl/fseq_pkg.sv @@
package fseq_pkg;

   localparam int MAX_FRAMES  = 1024;
   localparam int FRAME_LIMIT = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam int DIV_W       = 32;
   localparam int DIV_CNT_W   = 5;

   // operation codes
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_SET_FRAME  = 2'd1;
   localparam logic [1:0] OP_SET_PERIOD = 2'd2;

   // loop modes
   localparam logic [1:0] LOOP_WRAP      = 2'd0;
   localparam logic [1:0] LOOP_PINGPONG  = 2'd1;
   localparam logic [1:0] LOOP_PP_STOP   = 2'd2;
   localparam logic [1:0] LOOP_STOP_END  = 2'd3;

   // motion codes
   localparam logic [1:0] MOTION_FWD     = 2'd0;
   localparam logic [1:0] MOTION_BWD     = 2'd1;
   localparam logic [1:0] MOTION_STOPPED = 2'd2;

   // register indexes
   localparam logic CSR_FRAME_COUNT = 1'b0;
   localparam logic CSR_LOOP_MODE   = 1'b1;

   typedef enum logic [1:0] {
      KIND_TICK       = 2'd0,
      KIND_SET_FRAME  = 2'd1,
      KIND_SET_PERIOD = 2'd2,
      KIND_NOP        = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        elapsed_ms;
      logic [9:0]         frame_number;
      logic signed [15:0] period_ms;
   } req_type;

   typedef struct packed {
      logic [9:0] frame_index;
      logic [1:0] motion;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] elapsed_ms;
      logic [9:0]  frame_number;
      logic [15:0] period_ms;
   } cmd_type;

endpackage

@@ rtl/frame_sequencer_loop_modes_top.sv @@
// Animation frame sequencer. Each accepted word (tick, set frame, set period) returns one
// word with the frame index and motion after it. Words go into a two-entry queue and are
// executed one at a time. Set frame, set period, and a tick that makes no frame step do not
// use the divider; a tick that steps runs the shared one-bit-per-cycle 32-bit divider, and in
// wrap mode runs it twice over (first the step count, then that step count modulo
// the frame count). Registers: index 0 frame count (11 bits, zero reads as one, saturates
// at 1024), index 1 loop mode (0 wrap, 1 ping-pong, 2 ping-pong stopping at the first
// frame, 3 stop at either end). Write registers only while no word is in flight.
module frame_sequencer_loop_modes_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [10:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  fseq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fseq_pkg::rsp_type rsp_data
);
   import fseq_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_data;

   fseq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data)
   );

   fseq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/fseq_front.sv @@
module fseq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fseq_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_pop,
   output fseq_pkg::cmd_type q_data
);
   import fseq_pkg::*;

   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   cmd_type           entry_ff [QUEUE_DEPTH];
   cmd_type           cmd;
   logic              push;
   logic              pop;

   always_comb begin
      case (req_data.operation)
         OP_TICK:       cmd.kind = KIND_TICK;
         OP_SET_FRAME:  cmd.kind = KIND_SET_FRAME;
         OP_SET_PERIOD: cmd.kind = KIND_SET_PERIOD;
         default:       cmd.kind = KIND_NOP;
      endcase
      cmd.elapsed_ms   = req_data.elapsed_ms;
      cmd.frame_number = req_data.frame_number;
      cmd.period_ms    = req_data.period_ms;
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ rtl/fseq_div.sv @@
module fseq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fseq_pkg::DIV_W-1:0] dividend,
   input  logic [fseq_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [fseq_pkg::DIV_W-1:0] quotient,
   output logic [fseq_pkg::DIV_W-1:0] remainder
);
   import fseq_pkg::*;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/fseq_back.sv @@
module fseq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [10:0]       csr_wdata,
   input  logic              q_valid,
   output logic              q_pop,
   input  fseq_pkg::cmd_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fseq_pkg::rsp_type rsp_data
);
   import fseq_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_DIVK  = 5'b00100,
      ST_DIVS  = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [10:0] frame_count_ff;
   logic [1:0]  loop_mode_ff;
   logic [9:0]  frame_ff, frame_in;
   logic [15:0] period_ff, period_in;
   logic [31:0] acc_ff, acc_in;
   cmd_type     work_ff, work_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [10:0]      eff_n;
   logic [9:0]       last_frame;
   logic [9:0]       clamped_frame;
   logic [32:0]      acc_sum;
   logic [31:0]      acc_sat;
   logic [16:0]      mag;
   logic             fwd;
   logic             stopped;
   logic [15:0]      reversed;
   logic [10:0]      to_end;
   logic [9:0]       step_s;
   logic [10:0]      wrap_sum;
   logic [10:0]      wrap_frame;
   logic [1:0]       motion;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [DIV_W-1:0] div_rem;
   logic             out_free;

   fseq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // effective frame count: zero reads as one, large values saturate
   always_comb begin
      if (frame_count_ff == '0) begin
         eff_n = 11'd1;
      end else if (frame_count_ff > 11'(FRAME_LIMIT)) begin
         eff_n = 11'(FRAME_LIMIT);
      end else begin
         eff_n = frame_count_ff;
      end
   end

   assign last_frame    = 10'(eff_n - 11'd1);
   assign clamped_frame = ({1'b0, frame_ff} >= eff_n) ? last_frame : frame_ff;
   assign acc_sum       = {1'b0, acc_ff} + {17'd0, work_ff.elapsed_ms};
   assign acc_sat       = acc_sum[32] ? '1 : acc_sum[31:0];
   assign stopped       = (period_ff == '0);
   assign fwd           = !period_ff[15] && !stopped;
   assign mag           = period_ff[15] ? 17'd0 - {1'b1, period_ff} : {1'b0, period_ff};
   assign reversed      = (period_ff == 16'h8000) ? 16'h7fff : 16'd0 - period_ff;
   assign to_end        = fwd ? eff_n - {1'b0, frame_ff} : {1'b0, frame_ff} + 11'd1;
   assign step_s        = div_rem[9:0];
   assign wrap_sum      = fwd ? {1'b0, frame_ff} + {1'b0, step_s}
                              : {1'b0, frame_ff} + eff_n - {1'b0, step_s};
   assign wrap_frame    = (wrap_sum >= eff_n) ? wrap_sum - eff_n : wrap_sum;
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (stopped) begin
         motion = MOTION_STOPPED;
      end else if (period_ff[15]) begin
         motion = MOTION_BWD;
      end else begin
         motion = MOTION_FWD;
      end
   end

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      period_in    = period_ff;
      acc_in       = acc_ff;
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = acc_sat - 32'd1;
      div_divisor  = {15'd0, mag};
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               work_in  = q_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPLY;
            case (work_ff.kind)
               KIND_TICK: begin
                  frame_in = clamped_frame;
                  acc_in   = acc_sat;
                  if (!stopped && acc_sat > {15'd0, mag}) begin
                     div_start = 1'b1;
                     state_in  = ST_DIVK;
                  end
               end
               KIND_SET_FRAME: begin
                  frame_in = ({1'b0, work_ff.frame_number} >= eff_n) ? last_frame
                                                                     : work_ff.frame_number;
               end
               KIND_SET_PERIOD: begin
                  period_in = work_ff.period_ms;
               end
               default: begin
               end
            endcase
         end
         ST_DIVK: begin
            // quotient is the step count, remainder plus one is what stays
            div_dividend = div_quo;
            div_divisor  = {21'd0, eff_n};
            if (div_done) begin
               acc_in = div_rem + 32'd1;
               if (loop_mode_ff == LOOP_WRAP) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVS;
               end else begin
                  state_in = ST_REPLY;
                  if (div_quo < {21'd0, to_end}) begin
                     frame_in = fwd ? frame_ff + div_quo[9:0] : frame_ff - div_quo[9:0];
                  end else begin
                     acc_in = '0;
                     if (fwd) begin
                        frame_in  = last_frame;
                        period_in = (loop_mode_ff == LOOP_STOP_END) ? 16'd0 : reversed;
                     end else begin
                        frame_in  = '0;
                        period_in = (loop_mode_ff == LOOP_PINGPONG) ? reversed : 16'd0;
                     end
                  end
               end
            end
         end
         ST_DIVS: begin
            if (div_done) begin
               frame_in = wrap_frame[9:0];
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.frame_index = frame_ff;
               rsp_data_in.motion      = motion;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_ff       <= '0;
         period_ff      <= '0;
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= 11'd1;
         loop_mode_ff   <= LOOP_WRAP;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         period_ff    <= period_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_COUNT: frame_count_ff <= csr_wdata;
               CSR_LOOP_MODE:   loop_mode_ff   <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import fseq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [10:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   frame_sequencer_loop_modes_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sequencer state as the block should hold it
   logic [10:0]     seq_count = 11'd1;
   logic [1:0]      seq_mode = LOOP_WRAP;
   int unsigned     seq_frame = 0;
   int              seq_period = 0;
   longint unsigned seq_accum = 0;

   req_type     pending_words[$];
   rsp_type     expected_frames[$];
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          req_accepted = 1'b0;
   int unsigned mismatch_count = 0;

   function automatic longint unsigned frames_in_use();
      if (seq_count == 0) return 64'd1;
      if (seq_count > FRAME_LIMIT) return 64'(FRAME_LIMIT);
      return 64'(seq_count);
   endfunction

   function automatic void reverse_direction();
      seq_period = (seq_period == -32768) ? 32767 : -seq_period;
   endfunction

   function automatic rsp_type advance_sequencer(req_type w);
      longint unsigned n, acc, mag, steps, room, wrapped;
      bit              fwd;
      rsp_type         r;
      n = frames_in_use();
      case (w.operation)
         OP_TICK: begin
            if (seq_frame >= n) seq_frame = 32'(n - 1);
            acc = seq_accum + 64'(w.elapsed_ms);
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            seq_accum = acc;
            fwd = seq_period > 0;
            mag = fwd ? longint'(seq_period) : longint'(-seq_period);
            if (seq_period != 0 && acc > mag) begin
               steps = (acc - 1) / mag;
               room = fwd ? n - 64'(seq_frame) : 64'(seq_frame) + 1;
               if (seq_mode == LOOP_WRAP) begin
                  wrapped = steps % n;
                  seq_frame = fwd ? 32'((64'(seq_frame) + wrapped) % n)
                                  : 32'((64'(seq_frame) + n - wrapped) % n);
                  seq_accum = acc - steps * mag;
               end else if (steps < room) begin
                  seq_frame = fwd ? 32'(64'(seq_frame) + steps)
                                  : 32'(64'(seq_frame) - steps);
                  seq_accum = acc - steps * mag;
               end else begin
                  // hit an end: accumulator cleared, mode picks reverse or stop
                  seq_accum = 0;
                  if (fwd) begin
                     seq_frame = 32'(n - 1);
                     if (seq_mode == LOOP_STOP_END) seq_period = 0;
                     else reverse_direction();
                  end else begin
                     seq_frame = 0;
                     if (seq_mode == LOOP_PINGPONG) reverse_direction();
                     else seq_period = 0;
                  end
               end
            end
         end
         OP_SET_FRAME: begin
            seq_frame = (64'(w.frame_number) >= n) ? 32'(n - 1) : 32'(w.frame_number);
         end
         OP_SET_PERIOD: begin
            seq_period = int'(w.period_ms);
         end
         default: ;
      endcase
      r.frame_index = seq_frame[9:0];
      r.motion = (seq_period > 0) ? MOTION_FWD : (seq_period < 0) ? MOTION_BWD : MOTION_STOPPED;
      return r;
   endfunction

   function automatic void queue_word(logic [1:0] op, logic [15:0] elapsed,
                                      logic [9:0] fnum, int period);
      req_type w;
      w.operation = op;
      w.elapsed_ms = elapsed;
      w.frame_number = fnum;
      w.period_ms = 16'(period);
      pending_words = {pending_words, w};
   endfunction

   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      int          p;
      pick = $urandom_range(99);
      if (pick < 50) w.operation = OP_TICK;
      else if (pick < 65) w.operation = OP_SET_FRAME;
      else if (pick < 93) w.operation = OP_SET_PERIOD;
      else w.operation = KIND_NOP;
      case ($urandom_range(3))
         0: w.elapsed_ms = 16'($urandom_range(0, 3));
         1: w.elapsed_ms = 16'($urandom_range(0, 40));
         2: w.elapsed_ms = 16'($urandom_range(0, 400));
         default: w.elapsed_ms = 16'($urandom);
      endcase
      w.frame_number = $urandom_range(1) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      case ($urandom_range(7))
         0: p = 0;
         1: p = -32768;
         2: p = 32767;
         3: p = int'($signed(16'($urandom)));
         default: begin
            p = int'($urandom_range(1, 12));
            if ($urandom_range(1)) p = -p;
         end
      endcase
      w.period_ms = 16'(p);
      return w;
   endfunction

   task automatic write_reg(logic idx, logic [10:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_FRAME_COUNT) seq_count = value;
      else seq_mode = value[1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // everything sent, answered, and the slowest tick has had time to drain
   task automatic wait_quiet();
      while (pending_words.size() != 0 || req_valid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_setup();
      int unsigned c;
      case ($urandom_range(9))
         0: c = 0;
         1: c = 2047;
         2: c = 1024;
         3: c = 1;
         4: c = $urandom_range(0, 2047);
         default: c = $urandom_range(2, 12);
      endcase
      write_reg(CSR_FRAME_COUNT, 11'(c));
      // upper data bits are don't-care for the mode register
      write_reg(CSR_LOOP_MODE, 11'($urandom));
   endtask

   task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int words);
      int burst;
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      while (words > 0) begin
         wait_quiet();
         random_setup();
         burst = int'($urandom_range(30, 90));
         repeat (burst) pending_words = {pending_words, random_word()};
         words -= burst;
      end
   endtask

   // word driver and stall generator
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_accepted = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_accepted = 1'b1;
            expected_frames = {expected_frames, advance_sequencer(req_data)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word frame %0d motion %0d", $realtime,
                           rsp_data.frame_index, rsp_data.motion);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_data.frame_index !== want.frame_index ||
                   rsp_data.motion !== want.motion) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected frame %0d motion %0d, got frame %0d motion %0d",
                              $realtime, want.frame_index, want.motion,
                              rsp_data.frame_index, rsp_data.motion);
               end
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      stall_pct = 68;

      // single frame after reset, unused opcode, clamped set frame
      queue_word(OP_TICK, 16'd0, 10'd0, 0);
      queue_word(KIND_NOP, 16'hFFFF, 10'h3FF, -1);
      queue_word(OP_SET_FRAME, 16'd0, 10'd1023, 0);
      wait_quiet();
      // oversized count saturates, wrap with extreme periods
      write_reg(CSR_FRAME_COUNT, 11'd2047);
      queue_word(OP_SET_FRAME, 16'd0, 10'd1023, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 1);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, -32768);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 32767);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 0);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      queue_word(OP_SET_FRAME, 16'd0, 10'd900, 0);
      wait_quiet();
      // frame left beyond a lowered count
      write_reg(CSR_FRAME_COUNT, 11'd10);
      queue_word(OP_TICK, 16'd0, 10'd0, 0);
      wait_quiet();
      write_reg(CSR_FRAME_COUNT, 11'd0);
      queue_word(OP_SET_FRAME, 16'd0, 10'd5, 0);
      queue_word(OP_TICK, 16'd7, 10'd0, 0);
      wait_quiet();
      // ping-pong, most negative period reverses to max positive
      write_reg(CSR_FRAME_COUNT, 11'd4);
      write_reg(CSR_LOOP_MODE, 11'(LOOP_PINGPONG));
      queue_word(OP_SET_FRAME, 16'd0, 10'd3, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 1);
      queue_word(OP_TICK, 16'd10, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, -32768);
      queue_word(OP_SET_FRAME, 16'd0, 10'd0, 0);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      wait_quiet();
      write_reg(CSR_FRAME_COUNT, 11'd8);
      write_reg(CSR_LOOP_MODE, 11'(LOOP_PP_STOP));
      queue_word(OP_SET_FRAME, 16'd0, 10'd7, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, -1);
      queue_word(OP_TICK, 16'd100, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 3);
      queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      wait_quiet();
      write_reg(CSR_FRAME_COUNT, 11'd1024);
      write_reg(CSR_LOOP_MODE, 11'(LOOP_STOP_END));
      queue_word(OP_SET_FRAME, 16'd0, 10'd1023, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd2, 2);
      queue_word(OP_TICK, 16'd5, 10'd0, 0);

      run_phase(7, 68, 600);
      run_phase(68, 7, 600);
      run_phase(0, 0, 600);

      // stopped period builds up a large accumulator, then one huge step count
      wait_quiet();
      write_reg(CSR_FRAME_COUNT, 11'd1024);
      write_reg(CSR_LOOP_MODE, 11'(LOOP_WRAP));
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 0);
      repeat (40) queue_word(OP_TICK, 16'hFFFF, 10'd0, 0);
      queue_word(OP_SET_PERIOD, 16'd0, 10'd0, 1);
      queue_word(OP_TICK, 16'd1, 10'd0, 0);

      wait_quiet();
      if (mismatch_count == 0 && expected_frames.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
